### rtl/core/pai_pkg.sv
// ----------------------------------------------------------------------------
// pai_pkg: shared types and constants of the polyline interpolator
// Widths, transfer structs, action and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pai_pkg;

   localparam int MAX_POINTS = 256;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
   localparam int COORD_W    = 32;
   localparam int LEN_W      = 41;
   localparam int MU_W       = 17;
   localparam int TOL_W      = 13;
   localparam int ACC_W      = 66;
   localparam int ITER_W     = 67;
   localparam int MUL_W      = 33;

   localparam logic [MU_W-1:0]  MU_ONE  = 17'd65536;
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;
   localparam logic [1:0] ACT_NOP    = 2'd3;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_ZERO_LEN = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic [1:0]                action;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic [MU_W-1:0]           mu;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic [7:0]                segment_index;
      logic [LEN_W-1:0]          total_length;
      logic [1:0]                status;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } iter_ctrl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQ,
      S_SQRT,
      S_TGT,
      S_SCAN0,
      S_SCAN,
      S_DIV,
      S_PT0,
      S_PT1,
      S_PT2,
      S_LERP,
      S_DONE
   } seq_state_type;

endpackage

`default_nettype wire

### rtl/core/pai_store.sv
// ----------------------------------------------------------------------------
// pai_store: point and cumulative length memories
// One read/write port each, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pai_store (
   input  wire logic                        clock,
   input  wire logic                        pt_we,
   input  wire logic [pai_pkg::ADDR_W-1:0]  pt_addr,
   input  wire pai_pkg::point_type          pt_wdata,
   output pai_pkg::point_type               pt_rdata,
   input  wire logic                        cum_we,
   input  wire logic [pai_pkg::ADDR_W-1:0]  cum_addr,
   input  wire logic [pai_pkg::LEN_W-1:0]   cum_wdata,
   output logic [pai_pkg::LEN_W-1:0]        cum_rdata
);
   import pai_pkg::*;

   point_type        pt_mem [MAX_POINTS];
   logic [LEN_W-1:0] cum_mem [MAX_POINTS];

   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_addr] <= pt_wdata;
      end
      pt_rdata <= pt_mem[pt_addr];
   end

   always_ff @(posedge clock) begin
      if (cum_we) begin
         cum_mem[cum_addr] <= cum_wdata;
      end
      cum_rdata <= cum_mem[cum_addr];
   end

endmodule

`default_nettype wire

### rtl/core/pai_mul.sv
// ----------------------------------------------------------------------------
// pai_mul: registered unsigned multiplier
// Squares segment deltas and scales coordinate deltas by the fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module pai_mul (
   input  wire logic                           clock,
   input  wire logic [pai_pkg::MUL_W-1:0]      mul_a,
   input  wire logic [pai_pkg::MUL_W-1:0]      mul_b,
   output logic [2*pai_pkg::MUL_W-1:0]         prod_ff
);
   import pai_pkg::*;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

`default_nettype wire

### rtl/core/pai_iter.sv
// ----------------------------------------------------------------------------
// pai_iter: shared bit-serial square root and divider
// One compare-and-subtract per cycle; 33 steps for a root, 17 for a quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module pai_iter (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pai_pkg::iter_ctrl_type       ctrl,
   input  wire logic [pai_pkg::ACC_W-1:0]    radicand,
   input  wire logic [57:0]                  num,
   input  wire logic [pai_pkg::LEN_W-1:0]    den,
   output logic                              done,
   output logic [32:0]                       root,
   output logic [pai_pkg::MU_W-1:0]          quot
);
   import pai_pkg::*;

   logic [ITER_W-1:0] rem_ff, rem_in;
   logic [ITER_W-1:0] res_ff, res_in;
   logic [ITER_W-1:0] bit_ff, bit_in;
   logic [5:0]        step_ff, step_in;
   logic              run_ff, run_in;
   logic              mode_ff, mode_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] trial;
   logic              ge;

   always_comb begin
      trial   = mode_ff ? (res_ff + bit_ff) : bit_ff;
      ge      = (rem_ff >= trial);
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      step_in = step_ff;
      run_in  = run_ff;
      mode_in = mode_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         run_in  = 1'b1;
         mode_in = ctrl.sqrt_mode;
         res_in  = '0;
         if (ctrl.sqrt_mode) begin
            rem_in  = ITER_W'(radicand);
            bit_in  = ITER_W'(1) << 64;
            step_in = 6'd32;
         end else begin
            rem_in  = ITER_W'(num);
            bit_in  = ITER_W'({den, 16'b0});
            step_in = 6'd16;
         end
      end else if (run_ff) begin
         if (ge) begin
            rem_in = rem_ff - trial;
         end
         if (mode_ff) begin
            res_in = ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
            bit_in = bit_ff >> 2;
         end else begin
            res_in = {res_ff[ITER_W-2:0], ge};
            bit_in = bit_ff >> 1;
         end
         step_in = step_ff - 6'd1;
         if (step_ff == 6'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      step_ff <= step_in;
      mode_ff <= mode_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[32:0];
   assign quot = res_ff[MU_W-1:0];

endmodule

`default_nettype wire

### rtl/core/polyline_arclength_interpolator.sv
// ----------------------------------------------------------------------------
// polyline_arclength_interpolator: arc-length interpolation on a 3D polyline
// Stores points and running lengths; answers queries by fraction of length.
// ----------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  request   start, busy, req_data          transfer when start and !busy
//  response  rsp_valid, rsp_data            one-cycle strobe, never stalled
//  csr       csr_valid, csr_ready, csr_data transfer when valid and ready
//
//  Clear, no-op, rejected append and first append go straight to the done state.
//  Other appends square the deltas, then wait on the 33-step shared root unit.
//  Endpoint queries also go straight to done. Interior queries form the target,
//  scan the cumulative lengths (one memory read a cycle), divide, then blend;
//  this includes 17 shift-add steps for the target and 17 divider steps.
//  Reset is synchronous; the stores are not cleared and need no sweep.
//  busy is high from the transfer until the response strobe; the response
//  side cannot stall.
//
`default_nettype none

module polyline_arclength_interpolator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire pai_pkg::req_type            req_data,
   output logic                             rsp_valid,
   output pai_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [pai_pkg::TOL_W-1:0]   csr_data
);
   import pai_pkg::*;

   // coordinate c of a point
   function automatic logic signed [COORD_W-1:0] coord_of(point_type p, logic [1:0] c);
      logic signed [COORD_W-1:0] r;
      case (c)
         2'd0:    r = p.x;
         2'd1:    r = p.y;
         default: r = p.z;
      endcase
      return r;
   endfunction

   seq_state_type    state_ff, state_in;
   req_type          req_ff, req_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] total_ff, total_in;
   logic [TOL_W-1:0] tol_ff;
   point_type        first_ff, first_in;
   point_type        last_ff, last_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [MU_W-1:0]  m_ff, m_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [LEN_W-1:0] prev_ff, prev_in;
   logic             span_zero_ff, span_zero_in;
   logic [MU_W-1:0]  lam_ff, lam_in;
   point_type        p0_ff, p0_in;
   point_type        p1_ff, p1_in;
   logic [2:0]       neg_ff, neg_in;
   point_type        res_ff, res_in;
   logic [7:0]       seg_ff, seg_in;
   logic             rej_ff, rej_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // memory ports
   logic              pt_we, cum_we;
   logic [ADDR_W-1:0] pt_addr, cum_addr;
   point_type         pt_wdata, pt_rdata, req_point;
   logic [LEN_W-1:0]  cum_wdata, cum_rdata;

   // shared units
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [2*MUL_W-1:0] prod;
   iter_ctrl_type      iter_ctrl;
   logic [ACC_W-1:0]   radicand;
   logic [57:0]        num, target, lo_shift;
   logic [LEN_W-1:0]   den;
   logic               iter_done;
   logic [32:0]        root;
   logic [MU_W-1:0]    quot;

   // helpers
   logic               accept;
   logic [MU_W-1:0]    mu_clamp, hi_lim;
   logic [ADDR_W-1:0]  last_idx;
   logic signed [COORD_W-1:0] hi_c, lo_c, base_c;
   logic [32:0]        diff, abs_diff;
   logic [1:0]         col;
   logic [33:0]        mag, lerp_val;
   logic [LEN_W:0]     sum_len;
   logic [LEN_W-1:0]   sum_sat;
   logic               advance;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign req_point = '{x: req_data.point_x, y: req_data.point_y, z: req_data.point_z};
   assign mu_clamp  = (req_data.mu > MU_ONE) ? MU_ONE : req_data.mu;
   assign hi_lim    = MU_ONE - MU_W'(tol_ff);
   assign last_idx  = ADDR_W'(count_ff - COUNT_W'(1));

   // delta feeding the multiplier: segment delta on append, p1 - p0 on query
   always_comb begin
      if (state_ff == S_LERP) begin
         hi_c = coord_of(p1_ff, cnt_ff[1:0]);
         lo_c = coord_of(p0_ff, cnt_ff[1:0]);
      end else begin
         hi_c = coord_of('{x: req_ff.point_x, y: req_ff.point_y, z: req_ff.point_z},
                         cnt_ff[1:0]);
         lo_c = coord_of(last_ff, cnt_ff[1:0]);
      end
      diff     = {hi_c[COORD_W-1], hi_c} - {lo_c[COORD_W-1], lo_c};
      abs_diff = diff[32] ? (33'd0 - diff) : diff;
      mul_a    = abs_diff;
      mul_b    = (state_ff == S_LERP) ? MUL_W'(lam_ff) : abs_diff;
   end

   // product of the previous lane, applied to its base coordinate
   always_comb begin
      col      = 2'(cnt_ff - 5'd1);
      base_c   = coord_of(p0_ff, col);
      mag      = prod[49:16];
      lerp_val = neg_ff[col] ? ({{2{base_c[COORD_W-1]}}, base_c} - mag)
                             : ({{2{base_c[COORD_W-1]}}, base_c} + mag);
   end

   assign radicand = acc_ff + prod;
   assign target   = acc_ff[57:0];
   assign lo_shift = 58'({prev_ff, 16'b0});
   assign num      = (target > lo_shift) ? (target - lo_shift) : 58'd0;
   assign den      = cum_rdata - prev_ff;
   assign advance  = (i_ff < last_idx) && (58'({cum_rdata, 16'b0}) < target);
   assign sum_len  = {1'b0, total_ff} + (LEN_W+1)'(root);
   assign sum_sat  = sum_len[LEN_W] ? LEN_MAX : sum_len[LEN_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DONE;
               if (req_data.action == ACT_APPEND && count_ff != COUNT_W'(0)
                   && count_ff != COUNT_W'(MAX_POINTS)) begin
                  state_in = S_SQ;
               end else if (req_data.action == ACT_QUERY && count_ff != COUNT_W'(0)
                            && mu_clamp >= MU_W'(tol_ff) && mu_clamp <= hi_lim
                            && total_ff != '0) begin
                  state_in = S_TGT;
               end
            end
         end
         S_SQ:    if (cnt_ff == 5'd3) state_in = S_SQRT;
         S_SQRT:  if (iter_done) state_in = S_DONE;
         S_TGT:   if (cnt_ff == 5'd16) state_in = S_SCAN0;
         S_SCAN0: state_in = S_SCAN;
         S_SCAN:  if (!advance) state_in = S_DIV;
         S_DIV:   if (iter_done) state_in = S_PT0;
         S_PT0:   state_in = S_PT1;
         S_PT1:   state_in = S_PT2;
         S_PT2:   state_in = S_LERP;
         S_LERP:  if (cnt_ff == 5'd3) state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in       = req_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      i_in         = i_ff;
      prev_in      = prev_ff;
      span_zero_in = span_zero_ff;
      lam_in       = lam_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      seg_in       = seg_ff;
      rej_in       = rej_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pt_we        = 1'b0;
      pt_addr      = '0;
      pt_wdata     = req_point;
      cum_we       = 1'b0;
      cum_addr     = '0;
      cum_wdata    = '0;
      iter_ctrl    = '{start: 1'b0, sqrt_mode: 1'b0};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               res_in = '0;
               seg_in = '0;
               rej_in = 1'b0;
               acc_in = '0;
               cnt_in = '0;
               m_in   = mu_clamp;
               case (req_data.action)
                  ACT_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                  end
                  ACT_APPEND: begin
                     if (count_ff == COUNT_W'(MAX_POINTS)) begin
                        rej_in = 1'b1;
                     end else if (count_ff == COUNT_W'(0)) begin
                        // first point opens the line at length zero
                        pt_we    = 1'b1;
                        cum_we   = 1'b1;
                        first_in = req_point;
                        last_in  = req_point;
                        count_in = COUNT_W'(1);
                        total_in = '0;
                     end
                  end
                  ACT_QUERY: begin
                     if (count_ff != COUNT_W'(0)) begin
                        if (mu_clamp < MU_W'(tol_ff)) begin
                           res_in = first_ff;
                        end else if (mu_clamp > hi_lim) begin
                           res_in = last_ff;
                           seg_in = last_idx;
                        end else if (total_ff == '0) begin
                           res_in = first_ff;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SQ: begin
            // issue one lane a cycle, accumulate the product of the lane before
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff != 5'd0) begin
               acc_in = radicand;
            end
            if (cnt_ff == 5'd3) begin
               iter_ctrl = '{start: 1'b1, sqrt_mode: 1'b1};
            end
         end
         S_SQRT: begin
            if (iter_done) begin
               pt_we     = 1'b1;
               pt_addr   = count_ff[ADDR_W-1:0];
               pt_wdata  = '{x: req_ff.point_x, y: req_ff.point_y, z: req_ff.point_z};
               cum_we    = 1'b1;
               cum_addr  = count_ff[ADDR_W-1:0];
               cum_wdata = sum_sat;
               last_in   = pt_wdata;
               total_in  = sum_sat;
               count_in  = count_ff + COUNT_W'(1);
            end
         end
         S_TGT: begin
            // target = mu * total, one shift-add a cycle
            if (m_ff[cnt_ff]) begin
               acc_in = acc_ff + (ACC_W'(total_ff) << cnt_ff);
            end
            cnt_in = cnt_ff + 5'd1;
            i_in   = ADDR_W'(1);
            prev_in = '0;
         end
         S_SCAN0: begin
            cum_addr = i_ff;
         end
         S_SCAN: begin
            // read ahead one entry while testing the current one
            cum_addr = i_ff + ADDR_W'(1);
            if (advance) begin
               prev_in = cum_rdata;
               i_in    = i_ff + ADDR_W'(1);
            end else begin
               span_zero_in = (den == '0);
               iter_ctrl    = '{start: 1'b1, sqrt_mode: 1'b0};
            end
         end
         S_DIV: begin
            if (iter_done) begin
               lam_in = span_zero_ff ? '0 : ((quot > MU_ONE) ? MU_ONE : quot);
            end
         end
         S_PT0: begin
            pt_addr = i_ff - ADDR_W'(1);
         end
         S_PT1: begin
            pt_addr = i_ff;
            p0_in   = pt_rdata;
         end
         S_PT2: begin
            p1_in  = pt_rdata;
            cnt_in = '0;
         end
         S_LERP: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff != 5'd3) begin
               neg_in[cnt_ff[1:0]] = diff[32];
            end
            if (cnt_ff != 5'd0) begin
               case (col)
                  2'd0:    res_in.x = lerp_val[COORD_W-1:0];
                  2'd1:    res_in.y = lerp_val[COORD_W-1:0];
                  default: res_in.z = lerp_val[COORD_W-1:0];
               endcase
            end
            seg_in = i_ff - ADDR_W'(1);
         end
         S_DONE: begin
            rsp_valid_in         = 1'b1;
            rsp_in.out_x         = res_ff.x;
            rsp_in.out_y         = res_ff.y;
            rsp_in.out_z         = res_ff.z;
            rsp_in.segment_index = seg_ff;
            rsp_in.total_length  = total_ff;
            if (rej_ff) begin
               rsp_in.status = STAT_FULL;
            end else if (count_ff == '0) begin
               rsp_in.status = STAT_EMPTY;
            end else if (total_ff == '0) begin
               rsp_in.status = STAT_ZERO_LEN;
            end else begin
               rsp_in.status = STAT_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      acc_ff       <= acc_in;
      cnt_ff       <= cnt_in;
      m_ff         <= m_in;
      i_ff         <= i_in;
      prev_ff      <= prev_in;
      span_zero_ff <= span_zero_in;
      lam_ff       <= lam_in;
      p0_ff        <= p0_in;
      p1_ff        <= p1_in;
      neg_ff       <= neg_in;
      res_ff       <= res_in;
      seg_ff       <= seg_in;
      rej_ff       <= rej_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         tol_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            tol_ff <= csr_data;
         end
      end
   end

   pai_store u_store (
      .clock     (clock),
      .pt_we     (pt_we),
      .pt_addr   (pt_addr),
      .pt_wdata  (pt_wdata),
      .pt_rdata  (pt_rdata),
      .cum_we    (cum_we),
      .cum_addr  (cum_addr),
      .cum_wdata (cum_wdata),
      .cum_rdata (cum_rdata)
   );

   pai_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   pai_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (iter_ctrl),
      .radicand (radicand),
      .num      (num),
      .den      (den),
      .done     (iter_done),
      .root     (root),
      .quot     (quot)
   );

`ifndef ASSERT_OFF
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer accepted without going busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while still busy");
`endif

endmodule

`default_nettype wire

### tb/polyline_arclength_interpolator_test.sv
// ----------------------------------------------------------------------------
// polyline_arclength_interpolator_test: self-checking bench for the interpolator
// Drives clear, append, query and no-op commands through several tolerance
// settings, predicts each response in the bench and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module polyline_arclength_interpolator_test;
   import pai_pkg::*;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int SETTLE       = 200;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [TOL_W-1:0]     csr_data;

   polyline_arclength_interpolator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Bench copy of the line held by the block
   logic signed [COORD_W-1:0] line_x [MAX_POINTS];
   logic signed [COORD_W-1:0] line_y [MAX_POINTS];
   logic signed [COORD_W-1:0] line_z [MAX_POINTS];
   logic [LEN_W-1:0]          run_len [MAX_POINTS];
   int                        n_points;
   logic [TOL_W-1:0]          tolerance = '0;

   req_type pending_q [$];
   rsp_type awaited_q [$];

   bit      taken;
   bit      quiet;
   int      cycles;
   int      mismatches;
   int      n_sent, n_queries, n_appends, n_rejects, n_checked;
   int      n_tol_writes;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor of the square root of a sum of three squares
   function automatic logic [33:0] root_floor(logic [67:0] n);
      logic [33:0] r;
      logic [67:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         c = {34'd0, r | (34'd1 << b)};
         if (c * c <= n)
            r = r | (34'd1 << b);
      end
      return r;
   endfunction

   function automatic logic [67:0] square_of_gap(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
      longint d;
      logic [67:0] m;
      d = longint'(a) - longint'(b);
      if (d < 0)
         d = -d;
      m = 68'(d);
      return m * m;
   endfunction

   // p0 plus (p1 - p0) * lambda / one, truncated toward zero
   function automatic logic signed [COORD_W-1:0] blend(logic signed [COORD_W-1:0] p0,
                                                        logic signed [COORD_W-1:0] p1,
                                                        longint lambda);
      longint d, mag;
      d   = longint'(p1) - longint'(p0);
      mag = ((d < 0 ? -d : d) * lambda) >>> 16;
      return COORD_W'(d < 0 ? longint'(p0) - mag : longint'(p0) + mag);
   endfunction

   // Advance the bench line by one command and form the response it causes
   function automatic rsp_type interpolate_step(req_type c);
      rsp_type     r;
      bit          rejected;
      logic [41:0] sum;
      logic [33:0] seg_len;
      logic [LEN_W-1:0] total;
      longint      m, target, lo_len, span, num, lambda;
      int          last, pick, i;
      r        = '0;
      rejected = 0;
      if (c.action == ACT_CLEAR) begin
         n_points = 0;
      end else if (c.action == ACT_APPEND) begin
         if (n_points >= MAX_POINTS) begin
            rejected = 1;
         end else begin
            line_x[n_points] = c.point_x;
            line_y[n_points] = c.point_y;
            line_z[n_points] = c.point_z;
            if (n_points == 0) begin
               run_len[0] = '0;
            end else begin
               seg_len = root_floor(square_of_gap(c.point_x, line_x[n_points-1])
                                  + square_of_gap(c.point_y, line_y[n_points-1])
                                  + square_of_gap(c.point_z, line_z[n_points-1]));
               sum = {1'b0, run_len[n_points-1]} + 42'(seg_len);
               run_len[n_points] = sum > 42'(LEN_MAX) ? LEN_MAX : sum[LEN_W-1:0];
            end
            n_points++;
         end
      end
      total = n_points ? run_len[n_points-1] : '0;

      if (c.action == ACT_QUERY && n_points > 0) begin
         m    = c.mu > MU_ONE ? longint'(MU_ONE) : longint'(c.mu);
         last = n_points - 1;
         pick = -1;
         if (m < longint'(tolerance))
            pick = 0;
         else if (m > 65536 - longint'(tolerance))
            pick = last;
         else if (total == 0)
            pick = 0;
         else begin
            target = m * longint'(total);
            i = 1;
            while (i < last && (longint'(run_len[i]) << 16) < target)
               i++;
            lo_len = longint'(run_len[i-1]);
            span   = longint'(run_len[i]) - lo_len;
            num    = target > (lo_len << 16) ? target - (lo_len << 16) : 0;
            lambda = span != 0 ? num / span : 0;
            if (lambda > 65536)
               lambda = 65536;
            r.segment_index = 8'(i - 1);
            r.out_x = blend(line_x[i-1], line_x[i], lambda);
            r.out_y = blend(line_y[i-1], line_y[i], lambda);
            r.out_z = blend(line_z[i-1], line_z[i], lambda);
         end
         if (pick >= 0) begin
            r.segment_index = 8'(pick);
            r.out_x = line_x[pick];
            r.out_y = line_y[pick];
            r.out_z = line_z[pick];
         end
      end
      r.total_length = total;
      if (rejected)
         r.status = STAT_FULL;
      else if (n_points == 0)
         r.status = STAT_EMPTY;
      else if (total == 0)
         r.status = STAT_ZERO_LEN;
      else
         r.status = STAT_OK;
      return r;
   endfunction

   task automatic note_field(string name, logic [63:0] want, logic [63:0] got, ref bit bad);
      if (want !== got) begin
         bad = 1;
         if (mismatches < 10)
            $display("[%0d] %s: expected %h, got %h", cycles, name, want, got);
      end
   endtask

   task automatic check_response(rsp_type want, rsp_type got);
      bit bad;
      bad = 0;
      n_checked++;
      note_field("out_x", 64'(want.out_x), 64'(got.out_x), bad);
      note_field("out_y", 64'(want.out_y), 64'(got.out_y), bad);
      note_field("out_z", 64'(want.out_z), 64'(got.out_z), bad);
      note_field("segment_index", 64'(want.segment_index), 64'(got.segment_index), bad);
      note_field("total_length", 64'(want.total_length), 64'(got.total_length), bad);
      note_field("status", 64'(want.status), 64'(got.status), bad);
      if (bad)
         mismatches++;
   endtask

   // Sample at the rising edge: request and csr transfers, responses
   always @(posedge clock) begin
      if (!reset) begin
         cycles++;
         if (csr_valid && csr_ready) begin
            tolerance = csr_data;
            n_tol_writes++;
         end
         if (start && !busy) begin
            awaited_q.push_back(interpolate_step(req_data));
            taken = 1;
            n_sent++;
            if (req_data.action == ACT_QUERY)
               n_queries++;
         end
         if (rsp_valid) begin
            if (awaited_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0d] response with nothing awaited: %p", cycles, rsp_data);
            end else begin
               check_response(awaited_q.pop_front(), rsp_data);
            end
         end
      end
   end

   // Drive at the falling edge: move on only once the held command has
   // transferred; skip a drive with odds of 15 in a hundred unless in a quiet stretch
   always @(negedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else if (!start || taken) begin
         if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 15)) begin
            start    <= 1'b1;
            req_data <= pending_q.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
      taken = 0;
   end

   always @(posedge clock) begin
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, awaited_q.size());
         $display("polyline_arclength_interpolator_test: FAIL");
         $finish;
      end
   end

   task automatic push_cmd(logic [1:0] act, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [MU_W-1:0] mu);
      req_type c;
      c.action  = act;
      c.point_x = x;
      c.point_y = y;
      c.point_z = z;
      c.mu      = mu;
      pending_q.push_back(c);
      if (act == ACT_APPEND)
         n_appends++;
   endtask

   function automatic logic [MU_W-1:0] pick_mu();
      case ($urandom_range(9))
         0: return '0;
         1: return MU_ONE;
         2: return MU_W'($urandom_range(131071, 65537));
         3: return MU_W'($urandom_range(8192));
         4: return MU_W'($urandom_range(65536, 57344));
         default: return MU_W'($urandom_range(65536));
      endcase
   endfunction

   // Pick the next vertex: mostly a short hop, sometimes a repeat or a wild jump
   function automatic logic [31:0] hop(logic [31:0] prev, int spread);
      case ($urandom_range(9))
         0: return prev;
         1: return $urandom;
         default: return prev + 32'($signed($urandom_range(2 * spread)) - spread);
      endcase
   endfunction

   // Queue a fresh line of n points with queries sprinkled in
   task automatic queue_line(int n, int spread, int query_pct);
      logic [31:0] x, y, z;
      push_cmd(ACT_CLEAR, $urandom, $urandom, $urandom, pick_mu());
      x = $urandom;
      y = $urandom;
      z = $urandom;
      if ($urandom_range(1)) begin
         x = x >>> 8;
         y = y >>> 8;
         z = z >>> 8;
      end
      for (int k = 0; k < n; k++) begin
         push_cmd(ACT_APPEND, x, y, z, pick_mu());
         while ($urandom_range(99) < query_pct)
            push_cmd(ACT_QUERY, $urandom, $urandom, $urandom, pick_mu());
         if ($urandom_range(49) == 0)
            push_cmd(ACT_NOP, $urandom, $urandom, $urandom, pick_mu());
         x = hop(x, spread);
         y = hop(y, spread);
         z = hop(z, spread);
      end
      repeat ($urandom_range(4, 1))
         push_cmd(ACT_QUERY, $urandom, $urandom, $urandom, pick_mu());
   endtask

   // Hold until every queued command has transferred and every response is in
   task automatic drain();
      wait (pending_q.size() == 0 && !start && awaited_q.size() == 0);
      @(negedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      csr_valid = 1'b0;
      csr_data  = '0;
      quiet     = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty line, no-op, extreme coordinates, mu extremes
      push_cmd(ACT_QUERY, 0, 0, 0, 17'd32768);
      push_cmd(ACT_NOP, '1, '1, '1, '1);
      push_cmd(ACT_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      push_cmd(ACT_QUERY, 0, 0, 0, 17'd40000);
      push_cmd(ACT_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      push_cmd(ACT_QUERY, 0, 0, 0, 17'd1);
      push_cmd(ACT_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      push_cmd(ACT_QUERY, 0, 0, 0, 17'd0);
      push_cmd(ACT_QUERY, 0, 0, 0, MU_ONE);
      push_cmd(ACT_QUERY, 0, 0, 0, 17'h1FFFF);
      push_cmd(ACT_QUERY, 0, 0, 0, 17'd21845);
      push_cmd(ACT_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0);
      push_cmd(ACT_QUERY, 0, 0, 0, 17'd49152);
      push_cmd(ACT_CLEAR, 0, 0, 0, 0);
      push_cmd(ACT_APPEND, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 0);
      push_cmd(ACT_APPEND, 32'h0004_0000, 32'hFFFB_0000, 32'h0000_8000, 0);
      push_cmd(ACT_APPEND, 32'h0004_0000, 32'hFFFB_0000, 32'h0000_8000, 0);
      push_cmd(ACT_APPEND, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0003, 0);
      push_cmd(ACT_QUERY, 0, 0, 0, 17'd32768);
      push_cmd(ACT_QUERY, 0, 0, 0, 17'd65535);
      push_cmd(ACT_CLEAR, 0, 0, 0, 0);
      push_cmd(ACT_QUERY, 0, 0, 0, 17'd100);

      // Endpoint tolerance of 4096, then the full-store case
      write_tolerance(13'd4096);
      push_cmd(ACT_APPEND, 32'h0010_0000, 0, 0, 0);
      push_cmd(ACT_APPEND, 32'h0020_0000, 0, 0, 0);
      push_cmd(ACT_QUERY, 0, 0, 0, 17'd4095);
      push_cmd(ACT_QUERY, 0, 0, 0, 17'd4096);
      push_cmd(ACT_QUERY, 0, 0, 0, 17'd61440);
      push_cmd(ACT_QUERY, 0, 0, 0, 17'd61441);
      queue_line(MAX_POINTS + 2, 1 << 18, 3);

      // Widest tolerance the register holds: many queries fall in an endpoint band
      write_tolerance(13'h1FFF);
      repeat (8) queue_line($urandom_range(12, 1), 1 << 20, 30);

      // No idling on the request side for this stretch
      write_tolerance(13'd0);
      quiet = 1;
      repeat (10) queue_line($urandom_range(20, 2), 1 << 16, 35);
      drain();
      quiet = 0;

      // Random tolerances with mixed lines until enough commands have gone
      while (n_appends + n_queries < 900) begin
         write_tolerance(TOL_W'($urandom_range(4096)));
         repeat (4) queue_line($urandom_range(16, 1), 1 << $urandom_range(24, 4), 40);
         drain();
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d commands (%0d appends, %0d queries), %0d responses checked",
               n_sent, n_appends, n_queries, n_checked);
      $display("%0d tolerance writes, store filled to its limit and past it once",
               n_tol_writes);
      if (mismatches == 0 && awaited_q.size() == 0) begin
         $display("polyline_arclength_interpolator_test: PASS");
      end else begin
         $display("%0d mismatches, %0d responses never arrived", mismatches, awaited_q.size());
         $display("polyline_arclength_interpolator_test: FAIL");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/pai_pkg.sv
rtl/core/pai_store.sv
rtl/core/pai_mul.sv
rtl/core/pai_iter.sv
rtl/core/polyline_arclength_interpolator.sv
tb/polyline_arclength_interpolator_test.sv
